@@ hdl/plrd_pkg.sv @@
// Shared types, constants and the divider step for the point-lens ray deflection unit.
// No dependencies; every other file in hdl/ uses this package by scoped names.
package plrd_pkg;

    localparam int FRAC_BITS      = 18;
    localparam int MAX_LENSES     = 2;
    localparam int NUM_LENSES_DEF = 2;
    localparam int LANES          = 2 * MAX_LENSES;

    localparam int POS_W     = 24;
    localparam int MASS_W    = 22;
    localparam int SHR_W     = 19;
    localparam int OUT_W     = 32;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int DIFF_W    = POS_W + 1;
    localparam int R2_W      = 2 * DIFF_W;
    localparam int MNUM_W    = MASS_W + DIFF_W;
    localparam int NUM_W     = 46;
    localparam int DVD_W     = NUM_W + FRAC_BITS;
    localparam int FAC_W     = 21;
    localparam int LPROD_W   = POS_W + FAC_W;
    localparam int LIN_W     = LPROD_W - FRAC_BITS;
    localparam int SUM_W     = 64;

    localparam logic [POS_W-1:0]  RST_L0_X = POS_W'(241172);
    localparam logic [POS_W-1:0]  RST_L0_Y = POS_W'(26);
    localparam logic [MASS_W-1:0] RST_L0_M = MASS_W'(52429);
    localparam logic [POS_W-1:0]  RST_L1_X = POS_W'(-241172);
    localparam logic [POS_W-1:0]  RST_L1_Y = POS_W'(26);
    localparam logic [MASS_W-1:0] RST_L1_M = MASS_W'(524288);
    localparam logic [SHR_W-1:0]  RST_GAM  = SHR_W'(26214);
    localparam logic [SHR_W-1:0]  RST_KAP  = SHR_W'(0);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_L0_X  = 3'd0,
        CFG_L0_Y  = 3'd1,
        CFG_L0_M  = 3'd2,
        CFG_L1_X  = 3'd3,
        CFG_L1_Y  = 3'd4,
        CFG_L1_M  = 3'd5,
        CFG_GAMMA = 3'd6,
        CFG_KAPPA = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [POS_W-1:0] ray_x;
        logic signed [POS_W-1:0] ray_y;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] source_x;
        logic signed [OUT_W-1:0] source_y;
        logic                    singular_flag;
    } t_out;

    typedef struct packed {
        logic [MAX_LENSES-1:0][POS_W-1:0]  pos_x;
        logic [MAX_LENSES-1:0][POS_W-1:0]  pos_y;
        logic [MAX_LENSES-1:0][MASS_W-1:0] mass;
        logic [SHR_W-1:0]                  gamma;
        logic [SHR_W-1:0]                  kappa;
    } t_cfg;

    // One long-division lane: partial remainder, divisor, and the dividend
    // that shifts out at the top while quotient bits shift in at the bottom.
    typedef struct packed {
        logic [R2_W-1:0]  rem;
        logic [R2_W-1:0]  den;
        logic [DVD_W-1:0] acc;
    } t_lane;

    typedef struct packed {
        logic signed [LIN_W-1:0] lin_x;
        logic signed [LIN_W-1:0] lin_y;
        logic [MAX_LENSES-1:0]   zero;
        logic [MAX_LENSES-1:0]   neg_x;
        logic [MAX_LENSES-1:0]   neg_y;
    } t_side;

    function automatic t_lane div_step(input t_lane l);
        logic [R2_W:0] t;
        logic [R2_W:0] d;
        t_lane         r;
        t = {l.rem, l.acc[DVD_W-1]};
        d = {1'b0, l.den};
        r = l;
        if (t >= d) begin
            r.rem = R2_W'(t - d);
            r.acc = {l.acc[DVD_W-2:0], 1'b1};
        end else begin
            r.rem = t[R2_W-1:0];
            r.acc = {l.acc[DVD_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

@@ hdl/plrd_front.sv @@
// Front stages: lens offsets, squares, mass products and the shear term.
// Depends on plrd_pkg; feeds plrd_div.
module plrd_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  plrd_pkg::t_in                     i_item,
    input  plrd_pkg::t_cfg                    i_cfg,
    output logic                              o_vld,
    output plrd_pkg::t_lane [plrd_pkg::LANES-1:0] o_lane,
    output plrd_pkg::t_side                   o_side
);
    localparam int ML = plrd_pkg::MAX_LENSES;

    // Stage A: absolute offsets and signs.
    logic                                   r_a_vld;
    logic signed [plrd_pkg::POS_W-1:0]      r_a_rx, r_a_ry;
    logic signed [plrd_pkg::FAC_W-1:0]      r_a_fx, r_a_fy;
    logic [ML-1:0][plrd_pkg::DIFF_W-1:0]    r_a_ax, r_a_ay;
    logic [ML-1:0][plrd_pkg::MASS_W-1:0]    r_a_m;
    logic [ML-1:0]                          r_a_nx, r_a_ny;
    // Stage B: products.
    logic                                   r_b_vld;
    logic [ML-1:0][plrd_pkg::R2_W-1:0]      r_b_sqx, r_b_sqy;
    logic [ML-1:0][plrd_pkg::MNUM_W-1:0]    r_b_numx, r_b_numy;
    logic signed [plrd_pkg::LPROD_W-1:0]    r_b_px, r_b_py;
    logic [ML-1:0]                          r_b_nx, r_b_ny;
    // Stage C: lane setup.
    logic                                   r_c_vld;
    plrd_pkg::t_lane [plrd_pkg::LANES-1:0]  r_c_lane;
    plrd_pkg::t_side                        r_c_side;

    logic signed [plrd_pkg::FAC_W-1:0]      n_fx, n_fy, w_one, w_kap, w_gam;
    logic [ML-1:0][plrd_pkg::DIFF_W-1:0]    n_ax, n_ay;
    logic [ML-1:0]                          n_nx, n_ny;

    always_comb begin
        w_one = plrd_pkg::FAC_W'(1 << plrd_pkg::FRAC_BITS);
        w_kap = plrd_pkg::FAC_W'($signed(i_cfg.kappa));
        w_gam = plrd_pkg::FAC_W'($signed(i_cfg.gamma));
        n_fx  = w_one - w_kap + w_gam;
        n_fy  = w_one - w_kap - w_gam;
        for (int k = 0; k < ML; k++) begin
            logic signed [plrd_pkg::DIFF_W-1:0] dx, dy;
            dx = plrd_pkg::DIFF_W'($signed(i_cfg.pos_x[k]))
                 - plrd_pkg::DIFF_W'(i_item.ray_x);
            dy = plrd_pkg::DIFF_W'($signed(i_cfg.pos_y[k]))
                 - plrd_pkg::DIFF_W'(i_item.ray_y);
            n_nx[k] = dx[plrd_pkg::DIFF_W-1];
            n_ny[k] = dy[plrd_pkg::DIFF_W-1];
            n_ax[k] = n_nx[k] ? -dx : dx;
            n_ay[k] = n_ny[k] ? -dy : dy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_rx <= i_item.ray_x;
            r_a_ry <= i_item.ray_y;
            r_a_fx <= n_fx;
            r_a_fy <= n_fy;
            r_a_ax <= n_ax;
            r_a_ay <= n_ay;
            r_a_nx <= n_nx;
            r_a_ny <= n_ny;
            for (int k = 0; k < ML; k++) begin
                r_a_m[k] <= i_cfg.mass[k];
            end

            r_b_px <= plrd_pkg::LPROD_W'(r_a_rx) * plrd_pkg::LPROD_W'(r_a_fx);
            r_b_py <= plrd_pkg::LPROD_W'(r_a_ry) * plrd_pkg::LPROD_W'(r_a_fy);
            r_b_nx <= r_a_nx;
            r_b_ny <= r_a_ny;
            for (int k = 0; k < ML; k++) begin
                r_b_sqx[k]  <= plrd_pkg::R2_W'(r_a_ax[k]) * plrd_pkg::R2_W'(r_a_ax[k]);
                r_b_sqy[k]  <= plrd_pkg::R2_W'(r_a_ay[k]) * plrd_pkg::R2_W'(r_a_ay[k]);
                r_b_numx[k] <= plrd_pkg::MNUM_W'(r_a_m[k]) * plrd_pkg::MNUM_W'(r_a_ax[k]);
                r_b_numy[k] <= plrd_pkg::MNUM_W'(r_a_m[k]) * plrd_pkg::MNUM_W'(r_a_ay[k]);
            end

            r_c_side.lin_x <= r_b_px[plrd_pkg::LPROD_W-1:plrd_pkg::FRAC_BITS];
            r_c_side.lin_y <= r_b_py[plrd_pkg::LPROD_W-1:plrd_pkg::FRAC_BITS];
            r_c_side.neg_x <= r_b_nx;
            r_c_side.neg_y <= r_b_ny;
            for (int k = 0; k < ML; k++) begin
                logic [plrd_pkg::R2_W-1:0] r2;
                r2 = r_b_sqx[k] + r_b_sqy[k];
                r_c_side.zero[k]       <= (r2 == '0);
                r_c_lane[2*k].rem      <= '0;
                r_c_lane[2*k].den      <= r2;
                r_c_lane[2*k].acc      <= {r_b_numx[k][plrd_pkg::NUM_W-1:0],
                                           plrd_pkg::FRAC_BITS'(0)};
                r_c_lane[2*k+1].rem    <= '0;
                r_c_lane[2*k+1].den    <= r2;
                r_c_lane[2*k+1].acc    <= {r_b_numy[k][plrd_pkg::NUM_W-1:0],
                                           plrd_pkg::FRAC_BITS'(0)};
            end
        end
    end

    assign o_vld  = r_c_vld;
    assign o_lane = r_c_lane;
    assign o_side = r_c_side;
endmodule

@@ hdl/plrd_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, for all deflection lanes.
// Depends on plrd_pkg; fed by plrd_front, drains into plrd_back.
module plrd_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_vld,
    input  plrd_pkg::t_lane [plrd_pkg::LANES-1:0] i_lane,
    input  plrd_pkg::t_side                       i_side,
    output logic                                  o_vld,
    output logic [plrd_pkg::LANES-1:0][plrd_pkg::DVD_W-1:0] o_quot,
    output plrd_pkg::t_side                       o_side
);
    localparam int DEPTH = plrd_pkg::DVD_W;

    logic [DEPTH-1:0]                      r_vld;
    plrd_pkg::t_lane [plrd_pkg::LANES-1:0] r_lane [DEPTH];
    plrd_pkg::t_side                       r_side [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_vld};
        end
    end

    for (genvar s = 0; s < DEPTH; s++) begin : g_stage
        plrd_pkg::t_lane [plrd_pkg::LANES-1:0] w_in;
        plrd_pkg::t_side                       w_side;
        if (s == 0) begin : g_first
            assign w_in   = i_lane;
            assign w_side = i_side;
        end else begin : g_next
            assign w_in   = r_lane[s-1];
            assign w_side = r_side[s-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < plrd_pkg::LANES; l++) begin
                    r_lane[s][l] <= plrd_pkg::div_step(w_in[l]);
                end
                r_side[s] <= w_side;
            end
        end
    end

    always_comb begin
        for (int l = 0; l < plrd_pkg::LANES; l++) begin
            o_quot[l] = r_lane[DEPTH-1][l].acc;
        end
    end
    assign o_vld  = r_vld[DEPTH-1];
    assign o_side = r_side[DEPTH-1];

    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> r_vld == '0)
        else $error("divider valid bits not cleared by reset");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_vld))
        else $error("divider valid bits moved during a stall");
    a_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en |=> r_vld[DEPTH-1:1] == $past(r_vld[DEPTH-2:0]))
        else $error("divider valid bits lost or repeated on advance");
endmodule

@@ hdl/plrd_back.sv @@
// Back stages: signed deflection sum, shear term, saturation and output register.
// Depends on plrd_pkg; fed by plrd_div.
module plrd_back #(
    parameter int NUM_LENSES = plrd_pkg::NUM_LENSES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_vld,
    input  logic [plrd_pkg::LANES-1:0][plrd_pkg::DVD_W-1:0] i_quot,
    input  plrd_pkg::t_side                       i_side,
    output logic                                  o_vld,
    output plrd_pkg::t_out                        o_item
);
    localparam logic signed [plrd_pkg::SUM_W-1:0] OMAX =
        plrd_pkg::SUM_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [plrd_pkg::SUM_W-1:0] OMIN =
        plrd_pkg::SUM_W'(-64'sh0000_0000_8000_0000);

    logic                               r_d_vld, r_o_vld;
    logic signed [plrd_pkg::SUM_W-1:0]  r_d_sx, r_d_sy;
    logic                               r_d_flag;
    plrd_pkg::t_out                     r_out;

    logic signed [plrd_pkg::SUM_W-1:0]  n_sx, n_sy;
    logic                               n_flag;
    plrd_pkg::t_out                     n_out;

    always_comb begin
        n_sx   = plrd_pkg::SUM_W'(i_side.lin_x);
        n_sy   = plrd_pkg::SUM_W'(i_side.lin_y);
        n_flag = 1'b0;
        for (int k = 0; k < plrd_pkg::MAX_LENSES; k++) begin
            if (k < NUM_LENSES) begin
                if (i_side.zero[k]) begin
                    n_flag = 1'b1;
                end else begin
                    n_sx = i_side.neg_x[k] ? n_sx - $signed(i_quot[2*k])
                                           : n_sx + $signed(i_quot[2*k]);
                    n_sy = i_side.neg_y[k] ? n_sy - $signed(i_quot[2*k+1])
                                           : n_sy + $signed(i_quot[2*k+1]);
                end
            end
        end
    end

    always_comb begin
        n_out.singular_flag = r_d_flag;
        if (r_d_sx > OMAX) begin
            n_out.source_x = OMAX[plrd_pkg::OUT_W-1:0];
            n_out.singular_flag = 1'b1;
        end else if (r_d_sx < OMIN) begin
            n_out.source_x = OMIN[plrd_pkg::OUT_W-1:0];
            n_out.singular_flag = 1'b1;
        end else begin
            n_out.source_x = r_d_sx[plrd_pkg::OUT_W-1:0];
        end
        if (r_d_sy > OMAX) begin
            n_out.source_y = OMAX[plrd_pkg::OUT_W-1:0];
            n_out.singular_flag = 1'b1;
        end else if (r_d_sy < OMIN) begin
            n_out.source_y = OMIN[plrd_pkg::OUT_W-1:0];
            n_out.singular_flag = 1'b1;
        end else begin
            n_out.source_y = r_d_sy[plrd_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_d_vld <= i_vld;
            r_o_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_sx   <= n_sx;
            r_d_sy   <= n_sy;
            r_d_flag <= n_flag;
            r_out    <= n_out;
        end
    end

    assign o_vld  = r_o_vld;
    assign o_item = r_out;
endmodule

@@ hdl/point_lens_ray_deflection_unit.sv @@
// Point-lens ray deflection unit: a request passes from acceptance to result through
// 3 front stages, 64 divider stages at one quotient bit each, and 2 back stages.
// One request per cycle unless stalled; the 64-stage divider sets the latency.
// The pipeline advances whenever the output register is empty or being taken.
// Synchronous active-low reset clears all valid bits and loads register defaults.
module point_lens_ray_deflection_unit #(
    parameter int NUM_LENSES = plrd_pkg::NUM_LENSES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  plrd_pkg::t_in                       i_req_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output plrd_pkg::t_out                      o_rsp_data,
    input  logic                                i_cfg_we,
    input  logic [plrd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [plrd_pkg::CFG_W-1:0]          i_cfg_data
);
    plrd_pkg::t_cfg                        r_cfg;
    logic                                  w_en;
    logic                                  w_f_vld, w_d_vld;
    plrd_pkg::t_lane [plrd_pkg::LANES-1:0] w_lane;
    plrd_pkg::t_side                       w_f_side, w_d_side;
    logic [plrd_pkg::LANES-1:0][plrd_pkg::DVD_W-1:0] w_quot;

    // One global advance enable: every stage moves together, so a stall holds
    // each request (and each bubble) exactly where it is. An empty output register
    // lets the pipe keep advancing even while the consumer is not ready.
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    // Configuration registers. User writes only while the unit is idle; not enforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_x[0] <= plrd_pkg::RST_L0_X;
            r_cfg.pos_y[0] <= plrd_pkg::RST_L0_Y;
            r_cfg.mass[0]  <= plrd_pkg::RST_L0_M;
            r_cfg.pos_x[1] <= plrd_pkg::RST_L1_X;
            r_cfg.pos_y[1] <= plrd_pkg::RST_L1_Y;
            r_cfg.mass[1]  <= plrd_pkg::RST_L1_M;
            r_cfg.gamma    <= plrd_pkg::RST_GAM;
            r_cfg.kappa    <= plrd_pkg::RST_KAP;
        end else if (i_cfg_we) begin
            case (plrd_pkg::t_cfg_idx'(i_cfg_idx))
                plrd_pkg::CFG_L0_X: begin
                    r_cfg.pos_x[0] <= i_cfg_data[plrd_pkg::POS_W-1:0];
                end
                plrd_pkg::CFG_L0_Y: begin
                    r_cfg.pos_y[0] <= i_cfg_data[plrd_pkg::POS_W-1:0];
                end
                plrd_pkg::CFG_L0_M: begin
                    r_cfg.mass[0] <= i_cfg_data[plrd_pkg::MASS_W-1:0];
                end
                plrd_pkg::CFG_L1_X: begin
                    r_cfg.pos_x[1] <= i_cfg_data[plrd_pkg::POS_W-1:0];
                end
                plrd_pkg::CFG_L1_Y: begin
                    r_cfg.pos_y[1] <= i_cfg_data[plrd_pkg::POS_W-1:0];
                end
                plrd_pkg::CFG_L1_M: begin
                    r_cfg.mass[1] <= i_cfg_data[plrd_pkg::MASS_W-1:0];
                end
                plrd_pkg::CFG_GAMMA: begin
                    r_cfg.gamma <= i_cfg_data[plrd_pkg::SHR_W-1:0];
                end
                plrd_pkg::CFG_KAPPA: begin
                    r_cfg.kappa <= i_cfg_data[plrd_pkg::SHR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Front end forms the lens offsets, squared distance, mass-weighted
    // numerators and the smooth convergence/shear term.
    plrd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_valid && o_ready),
        .i_item  (i_req_data),
        .i_cfg   (r_cfg),
        .o_vld   (w_f_vld),
        .o_lane  (w_lane),
        .o_side  (w_f_side)
    );

    // Each lane divides mass*|offset|*2^FRAC by r^2, truncating.
    plrd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_f_vld),
        .i_lane  (w_lane),
        .i_side  (w_f_side),
        .o_vld   (w_d_vld),
        .o_quot  (w_quot),
        .o_side  (w_d_side)
    );

    // Back end applies signs, adds the smooth term, saturates to 32 bits and
    // raises the flag for a ray on a lens or a clamped coordinate.
    plrd_back #(
        .NUM_LENSES (NUM_LENSES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_d_vld),
        .i_quot  (w_quot),
        .i_side  (w_d_side),
        .o_vld   (o_valid),
        .o_item  (o_rsp_data)
    );
endmodule

@@ test/tb_point_lens_ray_deflection_unit.sv @@
// Self-checking testbench for point_lens_ray_deflection_unit: directed table, then random rays.
// Depends on plrd_pkg for the request, response and register index types.
module tb_point_lens_ray_deflection_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // Each directed row picks one of these register setups.
    typedef enum int {
        SETUP_RESET,
        SETUP_IDENTITY
    } t_setup;

    typedef struct {
        t_setup          setup;
        plrd_pkg::t_in   ray;
        bit              typed;
        plrd_pkg::t_out  rsp;
    } t_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_ready;
    plrd_pkg::t_in                  i_req_data = '0;
    logic                           o_valid;
    logic                           i_ready = 1'b0;
    plrd_pkg::t_out                 o_rsp_data;
    logic                           i_cfg_we = 1'b0;
    logic [plrd_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [plrd_pkg::CFG_W-1:0]     i_cfg_data = '0;

    // Testbench copy of the register file, kept in step with every write.
    logic [plrd_pkg::POS_W-1:0]  lens_x [plrd_pkg::MAX_LENSES];
    logic [plrd_pkg::POS_W-1:0]  lens_y [plrd_pkg::MAX_LENSES];
    logic [plrd_pkg::MASS_W-1:0] lens_m [plrd_pkg::MAX_LENSES];
    logic [plrd_pkg::SHR_W-1:0]  gamma_q;
    logic [plrd_pkg::SHR_W-1:0]  kappa_q;

    plrd_pkg::t_out pending_sources[$];
    int   fail_count = 0;
    int   rays_sent = 0;
    int   sources_seen = 0;
    int   flags_seen = 0;
    int   setups_run = 0;
    bit   quiet = 1'b0;

    point_lens_ray_deflection_unit u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_req_data(i_req_data),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_rsp_data(o_rsp_data),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // The source-plane position of one ray under the current register copy.
    // Lens deflections truncate toward zero; the linear shear term floors.
    function automatic plrd_pkg::t_out map_to_source(plrd_pkg::t_in ray);
        longint         rx, ry, dx, dy, sum_x, sum_y, fac_x, fac_y, sx, sy;
        logic [63:0]    ax, ay, r2, qx, qy;
        plrd_pkg::t_out res;
        rx = longint'(ray.ray_x);
        ry = longint'(ray.ray_y);
        sum_x = 0;
        sum_y = 0;
        res.singular_flag = 1'b0;
        for (int k = 0; k < plrd_pkg::MAX_LENSES; k++) begin
            dx = longint'($signed(lens_x[k])) - rx;
            dy = longint'($signed(lens_y[k])) - ry;
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            r2 = ax * ax + ay * ay;
            // A ray sitting exactly on a lens gets no pull from it, only the flag.
            if (r2 == 0) begin
                res.singular_flag = 1'b1;
                continue;
            end
            qx = ((64'(lens_m[k]) * ax) << plrd_pkg::FRAC_BITS) / r2;
            qy = ((64'(lens_m[k]) * ay) << plrd_pkg::FRAC_BITS) / r2;
            sum_x += (dx < 0) ? -longint'(qx) : longint'(qx);
            sum_y += (dy < 0) ? -longint'(qy) : longint'(qy);
        end
        fac_x = (longint'(1) << plrd_pkg::FRAC_BITS) - longint'($signed(kappa_q))
              + longint'($signed(gamma_q));
        fac_y = (longint'(1) << plrd_pkg::FRAC_BITS) - longint'($signed(kappa_q))
              - longint'($signed(gamma_q));
        sx = sum_x + ((rx * fac_x) >>> plrd_pkg::FRAC_BITS);
        sy = sum_y + ((ry * fac_y) >>> plrd_pkg::FRAC_BITS);
        // Either coordinate leaving the 32-bit range clamps and raises the flag.
        if (sx > 64'sd2147483647) begin
            sx = 64'sd2147483647;
            res.singular_flag = 1'b1;
        end else if (sx < -64'sd2147483648) begin
            sx = -64'sd2147483648;
            res.singular_flag = 1'b1;
        end
        if (sy > 64'sd2147483647) begin
            sy = 64'sd2147483647;
            res.singular_flag = 1'b1;
        end else if (sy < -64'sd2147483648) begin
            sy = -64'sd2147483648;
            res.singular_flag = 1'b1;
        end
        res.source_x = sx[plrd_pkg::OUT_W-1:0];
        res.source_y = sy[plrd_pkg::OUT_W-1:0];
        return res;
    endfunction

    // One register write per clock edge; the caller lowers the enable afterwards.
    task automatic write_reg(plrd_pkg::t_cfg_idx idx, logic [plrd_pkg::CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            plrd_pkg::CFG_L0_X:  lens_x[0] = value[plrd_pkg::POS_W-1:0];
            plrd_pkg::CFG_L0_Y:  lens_y[0] = value[plrd_pkg::POS_W-1:0];
            plrd_pkg::CFG_L0_M:  lens_m[0] = value[plrd_pkg::MASS_W-1:0];
            plrd_pkg::CFG_L1_X:  lens_x[1] = value[plrd_pkg::POS_W-1:0];
            plrd_pkg::CFG_L1_Y:  lens_y[1] = value[plrd_pkg::POS_W-1:0];
            plrd_pkg::CFG_L1_M:  lens_m[1] = value[plrd_pkg::MASS_W-1:0];
            plrd_pkg::CFG_GAMMA: gamma_q = value[plrd_pkg::SHR_W-1:0];
            plrd_pkg::CFG_KAPPA: kappa_q = value[plrd_pkg::SHR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_setup(logic [plrd_pkg::CFG_W-1:0] x0, logic [plrd_pkg::CFG_W-1:0] y0,
                              logic [plrd_pkg::CFG_W-1:0] m0, logic [plrd_pkg::CFG_W-1:0] x1,
                              logic [plrd_pkg::CFG_W-1:0] y1, logic [plrd_pkg::CFG_W-1:0] m1,
                              logic [plrd_pkg::CFG_W-1:0] g, logic [plrd_pkg::CFG_W-1:0] k);
        write_reg(plrd_pkg::CFG_L0_X, x0);
        write_reg(plrd_pkg::CFG_L0_Y, y0);
        write_reg(plrd_pkg::CFG_L0_M, m0);
        write_reg(plrd_pkg::CFG_L1_X, x1);
        write_reg(plrd_pkg::CFG_L1_Y, y1);
        write_reg(plrd_pkg::CFG_L1_M, m1);
        write_reg(plrd_pkg::CFG_GAMMA, g);
        write_reg(plrd_pkg::CFG_KAPPA, k);
        i_cfg_we <= 1'b0;
        setups_run++;
    endtask

    // Registers change only with the pipeline empty: every source has come
    // back, and the deep divider has had its full latency to flush.
    task automatic drain();
        while (pending_sources.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // Present one request, hold it until accepted, then file the expectation.
    // Each cycle before a request idles with a chance of about one in four.
    task automatic send_ray(plrd_pkg::t_in ray, bit typed, plrd_pkg::t_out rsp);
        while (!quiet && $urandom_range(99) < 24) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_data <= ray;
        do @(posedge i_clk); while (!o_ready);
        pending_sources.push_back(typed ? rsp : map_to_source(ray));
        rays_sent++;
    endtask

    // A random ray: mostly just beside a lens where the deflection is strong,
    // sometimes exactly on one, and the rest anywhere in the field.
    function automatic plrd_pkg::t_in random_ray();
        plrd_pkg::t_in r;
        int  k;
        int  mode;
        k = $urandom_range(plrd_pkg::MAX_LENSES - 1);
        mode = $urandom_range(9);
        if (mode <= 5) begin
            r.ray_x = lens_x[k] + plrd_pkg::POS_W'($urandom_range(2000) - 1000);
            r.ray_y = lens_y[k] + plrd_pkg::POS_W'($urandom_range(2000) - 1000);
        end else if (mode == 6) begin
            r.ray_x = lens_x[k];
            r.ray_y = lens_y[k];
        end else begin
            r.ray_x = plrd_pkg::POS_W'($urandom);
            r.ray_y = plrd_pkg::POS_W'($urandom);
        end
        return r;
    endfunction

    // The receiving side stalls at random, except during a quiet stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= quiet || ($urandom_range(99) >= 24);
        end
    end

    // Response checker: every accepted source is matched against the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin
        plrd_pkg::t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            sources_seen++;
            if (o_rsp_data.singular_flag) flags_seen++;
            if (pending_sources.size() == 0) begin
                $error("unexpected source result %h", o_rsp_data);
                fail_count++;
            end else begin
                want = pending_sources.pop_front();
                if (o_rsp_data.source_x !== want.source_x) begin
                    $error("source_x expected %0d got %0d", want.source_x,
                           o_rsp_data.source_x);
                    fail_count++;
                end
                if (o_rsp_data.source_y !== want.source_y) begin
                    $error("source_y expected %0d got %0d", want.source_y,
                           o_rsp_data.source_y);
                    fail_count++;
                end
                if (o_rsp_data.singular_flag !== want.singular_flag) begin
                    $error("singular_flag expected %0d got %0d", want.singular_flag,
                           o_rsp_data.singular_flag);
                    fail_count++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, then random setups with random rays.
    initial begin
        t_row           rows[$];
        t_setup         cur;
        plrd_pkg::t_out none;
        none = '0;
        lens_x[0] = plrd_pkg::RST_L0_X;
        lens_y[0] = plrd_pkg::RST_L0_Y;
        lens_m[0] = plrd_pkg::RST_L0_M;
        lens_x[1] = plrd_pkg::RST_L1_X;
        lens_y[1] = plrd_pkg::RST_L1_Y;
        lens_m[1] = plrd_pkg::RST_L1_M;
        gamma_q   = plrd_pkg::RST_GAM;
        kappa_q   = plrd_pkg::RST_KAP;

        // Under the reset registers: origin, field corners, rays on each lens,
        // and two a single step beside the first lens.
        rows.push_back('{SETUP_RESET, '{24'sd0, 24'sd0}, 1'b0, none});
        rows.push_back('{SETUP_RESET, '{24'sd8388607, 24'sd8388607}, 1'b0, none});
        rows.push_back('{SETUP_RESET, '{-24'sd8388608, -24'sd8388608}, 1'b0, none});
        rows.push_back('{SETUP_RESET, '{24'sd8388607, -24'sd8388608}, 1'b0, none});
        rows.push_back('{SETUP_RESET, '{-24'sd8388608, 24'sd8388607}, 1'b0, none});
        rows.push_back('{SETUP_RESET, '{24'sd241172, 24'sd26}, 1'b0, none});
        rows.push_back('{SETUP_RESET, '{-24'sd241172, 24'sd26}, 1'b0, none});
        rows.push_back('{SETUP_RESET, '{24'sd241173, 24'sd26}, 1'b0, none});
        rows.push_back('{SETUP_RESET, '{24'sd241172, 24'sd27}, 1'b0, none});
        // Massless lenses at the origin, no shear or convergence: the source
        // is the ray itself, flagged only when the ray lands on the origin.
        rows.push_back('{SETUP_IDENTITY, '{24'sd0, 24'sd0}, 1'b1, '{32'sd0, 32'sd0, 1'b1}});
        rows.push_back('{SETUP_IDENTITY, '{24'sd8388607, 24'sd8388607}, 1'b1,
                         '{32'sd8388607, 32'sd8388607, 1'b0}});
        rows.push_back('{SETUP_IDENTITY, '{-24'sd8388608, -24'sd8388608}, 1'b1,
                         '{-32'sd8388608, -32'sd8388608, 1'b0}});
        rows.push_back('{SETUP_IDENTITY, '{24'sd1, -24'sd1}, 1'b1,
                         '{32'sd1, -32'sd1, 1'b0}});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cur = SETUP_RESET;
        foreach (rows[i]) begin
            if (rows[i].setup != cur) begin
                i_valid <= 1'b0;
                drain();
                load_setup(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
                cur = rows[i].setup;
            end
            send_ray(rows[i].ray, rows[i].typed, rows[i].rsp);
        end

        // Random phases: the extremes first, then random lens layouts. One
        // phase runs without any idling on either side.
        for (int p = 0; p < 6; p++) begin
            i_valid <= 1'b0;
            drain();
            case (p)
                0: load_setup(24'h7FFFFF, 24'h7FFFFF, 24'h3FFFFF, 24'h800000, 24'h800000,
                              24'h3FFFFF, 24'h03FFFF, 24'h040000);
                1: load_setup(24'h800000, 24'h000000, 24'h000000, 24'h7FFFFF, 24'hFFFFFF,
                              24'h3FFFFF, 24'h040000, 24'h03FFFF);
                default: load_setup(plrd_pkg::CFG_W'($urandom), plrd_pkg::CFG_W'($urandom),
                                    plrd_pkg::CFG_W'($urandom), plrd_pkg::CFG_W'($urandom),
                                    plrd_pkg::CFG_W'($urandom), plrd_pkg::CFG_W'($urandom),
                                    plrd_pkg::CFG_W'($urandom), plrd_pkg::CFG_W'($urandom));
            endcase
            quiet = (p == 3);
            repeat (156) send_ray(random_ray(), 1'b0, none);
            quiet = 1'b0;
        end
        i_valid <= 1'b0;

        drain();
        $display("%0d rays sent over %0d register setups, %0d sources checked, %0d flagged",
                 rays_sent, setups_run, sources_seen, flags_seen);
        if (fail_count == 0 && pending_sources.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
